/* sv/wrhs_pkg.sv */
// Shared types, constants and the generator step for the weighted hop selector.
`timescale 1ns / 1ps
`default_nettype none

package wrhs_pkg;

    localparam int MAX_CANDIDATES_DEF = 8;
    localparam int SCORE_BITS_DEF     = 16;

    localparam int SCORE_FIELDS = 8;
    localparam int FIELD_BITS   = 16;
    localparam int COUNT_BITS   = 4;
    localparam int INDEX_BITS   = 3;

    localparam logic [31:0] PRNG_SEED = 32'hCAFE_BABE;

    // u = x mod DRAW_RANGE, with x / DRAW_RANGE = (x * DRAW_MAGIC) >> DRAW_SHIFT
    localparam int          DRAW_RANGE = 10000;
    localparam int          DRAW_BITS  = 14;
    localparam logic [31:0] DRAW_MAGIC = 32'hD1B7_1759;
    localparam int          DRAW_SHIFT = 45;
    localparam int          QUOT_BITS  = 64 - DRAW_SHIFT;

    typedef struct packed {
        logic [COUNT_BITS-1:0] candidate_count;
        logic [FIELD_BITS-1:0] score_0;
        logic [FIELD_BITS-1:0] score_1;
        logic [FIELD_BITS-1:0] score_2;
        logic [FIELD_BITS-1:0] score_3;
        logic [FIELD_BITS-1:0] score_4;
        logic [FIELD_BITS-1:0] score_5;
        logic [FIELD_BITS-1:0] score_6;
        logic [FIELD_BITS-1:0] score_7;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] hop_index;
        logic                  hop_valid;
    } t_out_item;

    // Per-item control carried alongside the data path
    typedef struct packed {
        logic                  vld;
        logic                  hop_valid;
        logic                  force_zero;
        logic [INDEX_BITS-1:0] last;
    } t_ctl;

    function automatic logic [31:0] xorshift_next(input logic [31:0] w);
        logic [31:0] x;
        x = (w == 32'd0) ? PRNG_SEED : w;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

`default_nettype wire

/* sv/weighted_random_hop_select.sv */
// Weighted random hop selector: picks one candidate index with odds set by its score.
//
// Input channel (i_valid / o_stall / i_item): one item carries a candidate count and
// eight scores. An item is taken at each edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall / o_item): one result per item, in order, giving
// hop_index and hop_valid (low when the count is zero).
// Throughput: one item per cycle unless the output stalls. Each lane scales its own
// prefix sum while a shared draw path reduces the xorshift32 word modulo 10000 and
// multiplies it by the total; the generator word itself advances at the accepting edge
// of each item that is not forced to index zero, so items follow back to back.
// Reset: i_rst_n low at a clock edge clears the generator word and empties the pipe.
// Stall: while a result waits with i_stall high the whole pipe holds and o_stall
// rises; o_stall is low whenever the output register is empty or being taken.
`timescale 1ns / 1ps
`default_nettype none

module weighted_random_hop_select #(
    parameter int MAX_CANDIDATES = wrhs_pkg::MAX_CANDIDATES_DEF,
    parameter int SCORE_BITS     = wrhs_pkg::SCORE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire wrhs_pkg::t_in_item    i_item,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output wrhs_pkg::t_out_item        o_item
);
    import wrhs_pkg::*;

    localparam int NL = (MAX_CANDIDATES < SCORE_FIELDS) ? MAX_CANDIDATES : SCORE_FIELDS;
    localparam int SW = (SCORE_BITS < FIELD_BITS) ? SCORE_BITS : FIELD_BITS;
    localparam int PW = SW + $clog2(NL);
    localparam int XW = PW + DRAW_BITS;
    localparam int STAGES = 5;

    logic [FIELD_BITS-1:0]   w_fields [SCORE_FIELDS];
    logic [NL-1:0][SW-1:0]   w_scores;
    logic [NL-1:0][SW-1:0]   r_scores;
    logic [COUNT_BITS-1:0]   w_count_sat;
    logic                    w_force_zero;
    logic                    w_en;
    logic                    w_accept;
    logic                    w_advance;
    t_ctl                    w_ctl_in;
    t_ctl                    r_ctl [STAGES];
    logic [PW-1:0]           w_prefix [NL];
    logic [NL-1:0]           w_hit;
    logic [PW-1:0]           r_total2;
    logic [XW-1:0]           w_ut;
    t_out_item               w_merged;
    t_out_item               r_out;
    logic                    r_out_vld;

    assign w_fields[0] = i_item.score_0;
    assign w_fields[1] = i_item.score_1;
    assign w_fields[2] = i_item.score_2;
    assign w_fields[3] = i_item.score_3;
    assign w_fields[4] = i_item.score_4;
    assign w_fields[5] = i_item.score_5;
    assign w_fields[6] = i_item.score_6;
    assign w_fields[7] = i_item.score_7;

    // Saturate the count, then drop uncounted scores so later lanes add nothing
    assign w_count_sat = (i_item.candidate_count > COUNT_BITS'(NL)) ?
                         COUNT_BITS'(NL) : i_item.candidate_count;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            w_scores[i] = (COUNT_BITS'(i) < w_count_sat) ? w_fields[i][SW-1:0] : '0;
        end
    end

    assign w_force_zero = (w_count_sat < COUNT_BITS'(2)) || !(|w_scores);

    assign w_en      = !r_out_vld || !i_stall;
    assign o_stall   = !w_en;
    assign w_accept  = i_valid && w_en;
    assign w_advance = w_accept && !w_force_zero;

    assign w_ctl_in.vld        = i_valid;
    assign w_ctl_in.hop_valid  = (w_count_sat != '0);
    assign w_ctl_in.force_zero = w_force_zero;
    assign w_ctl_in.last       = INDEX_BITS'(w_count_sat - COUNT_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_ctl[s] <= '0;
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_ctl[0] <= w_ctl_in;
            for (int s = 1; s < STAGES; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
            r_out_vld <= r_ctl[STAGES-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_scores <= w_scores;
            r_total2 <= w_prefix[NL-1];
            r_out    <= w_merged;
        end
    end

    wrhs_draw #(
        .PW (PW)
    ) u_draw (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_advance (w_advance),
        .i_total   (r_total2),
        .o_ut      (w_ut)
    );

    for (genvar g = 0; g < NL; g++) begin : g_lane
        wrhs_lane #(
            .LANE  (g),
            .LANES (NL),
            .SW    (SW),
            .PW    (PW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_scores (r_scores),
            .i_ut     (w_ut),
            .o_prefix (w_prefix[g]),
            .o_hit    (w_hit[g])
        );
    end

    wrhs_merge #(
        .LANES (NL)
    ) u_merge (
        .i_hit  (w_hit),
        .i_ctl  (r_ctl[STAGES-1]),
        .o_item (w_merged)
    );

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    a_no_hop_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.hop_valid) |-> (o_item.hop_index == '0))
        else $error("hop_index nonzero on an item without a hop");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.hop_index <= INDEX_BITS'(NL - 1)))
        else $error("hop_index beyond the candidate lanes");

    a_last_stage_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_ctl[STAGES-1].vld) |=> o_valid)
        else $error("item lost between last stage and output register");

endmodule

`default_nettype wire

/* sv/wrhs_draw.sv */
// Generator word, draw modulo reduction and the shared u * total product.
`timescale 1ns / 1ps
`default_nettype none

module wrhs_draw #(
    parameter int PW = 19
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_advance,
    input  wire logic [PW-1:0]                       i_total,
    output logic      [PW+wrhs_pkg::DRAW_BITS-1:0]   o_ut
);
    import wrhs_pkg::*;

    localparam int XW = PW + DRAW_BITS;

    logic [31:0]           r_prng;
    logic [31:0]           n_prng;
    logic [31:0]           r_x0;
    logic [31:0]           r_x1;
    logic [QUOT_BITS-1:0]  r_q1;
    logic [DRAW_BITS-1:0]  r_u2;
    logic [XW-1:0]         r_ut3;
    logic [63:0]           w_prod;
    logic [31:0]           w_qx;

    assign n_prng = xorshift_next(r_prng);
    assign w_prod = 64'(r_x0) * 64'(DRAW_MAGIC);
    assign w_qx   = 32'(r_q1) * 32'(DRAW_RANGE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prng <= '0;
        end else if (i_advance) begin
            r_prng <= n_prng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0  <= n_prng;
            r_x1  <= r_x0;
            r_q1  <= QUOT_BITS'(w_prod >> DRAW_SHIFT);
            r_u2  <= DRAW_BITS'(r_x1 - w_qx);
            r_ut3 <= XW'(r_u2) * XW'(i_total);
        end
    end

    assign o_ut = r_ut3;

endmodule

`default_nettype wire

/* sv/wrhs_lane.sv */
// One candidate lane: prefix sum, scaled threshold and compare against the draw.
`timescale 1ns / 1ps
`default_nettype none

module wrhs_lane #(
    parameter int LANE  = 0,
    parameter int LANES = 8,
    parameter int SW    = 16,
    parameter int PW    = 19
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic [LANES-1:0][SW-1:0]              i_scores,
    input  wire logic [PW+wrhs_pkg::DRAW_BITS-1:0]     i_ut,
    output logic      [PW-1:0]                         o_prefix,
    output logic                                       o_hit
);
    import wrhs_pkg::*;

    localparam int XW = PW + DRAW_BITS;

    logic [PW-1:0] w_sum;
    logic [PW-1:0] r_pre1;
    logic [XW-1:0] r_scaled2;
    logic [XW-1:0] r_scaled3;
    logic          r_hit4;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k <= LANE; k++) begin
            w_sum = w_sum + PW'(i_scores[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre1    <= w_sum;
            r_scaled2 <= XW'(r_pre1) * XW'(DRAW_RANGE);
            r_scaled3 <= r_scaled2;
            r_hit4    <= i_ut < r_scaled3;
        end
    end

    assign o_prefix = r_pre1;
    assign o_hit    = r_hit4;

endmodule

`default_nettype wire

/* sv/wrhs_merge.sv */
// Merge lane hits into an index: lowest hit wins, else the last candidate, or 0 if forced.
`timescale 1ns / 1ps
`default_nettype none

module wrhs_merge #(
    parameter int LANES = 8
) (
    input  wire logic [LANES-1:0]    i_hit,
    input  wire wrhs_pkg::t_ctl      i_ctl,
    output wrhs_pkg::t_out_item      o_item
);
    import wrhs_pkg::*;

    logic [INDEX_BITS-1:0] w_pick;

    always_comb begin
        w_pick = i_ctl.last;
        for (int k = LANES - 1; k >= 0; k--) begin
            if (i_hit[k]) begin
                w_pick = INDEX_BITS'(k);
            end
        end
        o_item.hop_valid = i_ctl.hop_valid;
        o_item.hop_index = i_ctl.force_zero ? '0 : w_pick;
    end

endmodule

`default_nettype wire
